// ===== rtl/tsac_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch sample averaging and calibration: shared package
// Widths, register indexes, reset values, the status word of one axis lane
// and the final clamp to the screen area.
// ----------------------------------------------------------------------------
package tsac_pkg;

   // Field widths.
   localparam int CFG_W     = 12;
   localparam int RAW_W     = 12;
   localparam int POS_W     = 11;
   localparam int ORIENT_W  = 3;
   localparam int CSR_IDX_W = 3;

   // Product of a 12-bit magnitude and a 12-bit size, and the signed
   // quotient that comes out of the mapping divide.
   localparam int PROD_W = 2 * CFG_W;
   localparam int VAL_W  = PROD_W + 1;
   // Room for the invert step on top of the signed quotient.
   localparam int FIN_W  = VAL_W + 2;

   localparam int REJECT_BELOW = 32;
   localparam int OUT_MAX      = 2047;

   // Defaults of the top-level parameters.
   localparam int SAMPLES_DEF  = 4;
   localparam int RAW_BITS_DEF = 12;

   // Register reset values.
   localparam logic [CFG_W-1:0]    RST_RAW_MIN = 12'd200;
   localparam logic [CFG_W-1:0]    RST_RAW_MAX = 12'd3900;
   localparam logic [CFG_W-1:0]    RST_SIZE    = 12'd240;
   localparam logic [ORIENT_W-1:0] RST_ORIENT  = 3'd0;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_X_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_MAX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ORIENT = 3'd6;

   // Bits of the orientation register.
   localparam int ORIENT_INV_X = 0;
   localparam int ORIENT_INV_Y = 1;
   localparam int ORIENT_SWAP  = 2;

   // Status of one axis lane, as seen by the controller.
   typedef struct packed {
      logic                    done;
      logic                    low;
      logic signed [VAL_W-1:0] value;
   } axis_stat_type;

   // Clamp a signed coordinate to 0 .. min(size - 1, OUT_MAX).
   function automatic logic [POS_W-1:0] clamp_pos(input logic signed [FIN_W-1:0] v,
                                                  input logic [CFG_W-1:0] size);
      logic [CFG_W-1:0] top;
      logic [POS_W-1:0] res;
      if (size == '0) begin
         top = '0;
      end else begin
         top = size - 1'b1;
      end
      if (top > CFG_W'(OUT_MAX)) begin
         top = CFG_W'(OUT_MAX);
      end
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({{(FIN_W-CFG_W){1'b0}}, top})) begin
         res = top[POS_W-1:0];
      end else begin
         res = v[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/tsac_div.sv =====
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle. The dividend shifts out of
// the top of the quotient register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module tsac_div #(
   parameter int NUM_W = tsac_pkg::PROD_W,
   parameter int DEN_W = tsac_pkg::CFG_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = num;
         rem_in = '0;
         den_in = den;
      end else if (run_ff) begin
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/tsac_axis.sv =====
// ----------------------------------------------------------------------------
// Axis lane
// Averages one axis sum with the serial divider, forms |avg - min| * size
// with a bit-serial shift-add multiplier, then divides by |max - min| on the
// same divider and applies the sign, truncating toward zero.
// ----------------------------------------------------------------------------
module tsac_axis #(
   parameter int SAMPLES = tsac_pkg::SAMPLES_DEF,
   parameter int SUM_W   = tsac_pkg::RAW_W + 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SUM_W-1:0]               sum,
   input  logic [tsac_pkg::CFG_W-1:0]     raw_min,
   input  logic [tsac_pkg::CFG_W-1:0]     raw_max,
   input  logic [tsac_pkg::CFG_W-1:0]     size,
   output tsac_pkg::axis_stat_type        stat
);

   localparam int CW        = tsac_pkg::CFG_W;
   localparam int PW        = tsac_pkg::PROD_W;
   localparam int VW        = tsac_pkg::VAL_W;
   localparam int MUL_STEPS = CW;
   localparam int MCNT_W    = $clog2(MUL_STEPS);

   localparam logic [1:0] AX_IDLE = 2'd0;
   localparam logic [1:0] AX_AVG  = 2'd1;
   localparam logic [1:0] AX_MUL  = 2'd2;
   localparam logic [1:0] AX_DIV  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [MCNT_W-1:0]    mcnt_ff, mcnt_in;
   logic                 neg_ff, neg_in;
   logic                 span_zero_ff, span_zero_in;
   logic [CW-1:0]        span_mag_ff, span_mag_in;
   logic                 low_ff, low_in;
   logic signed [VW-1:0] value_ff, value_in;
   logic                 done_ff, done_in;

   logic                 div_start;
   logic [PW-1:0]        div_num;
   logic [CW-1:0]        div_den;
   logic                 div_done;
   logic [PW-1:0]        div_quo;

   logic [CW-1:0]        avg;
   logic [CW:0]          diff;
   logic [CW:0]          diff_flip;
   logic [CW:0]          span;
   logic [CW:0]          span_flip;
   logic [CW-1:0]        diff_mag;
   logic [CW:0]          mul_add;
   logic [PW-1:0]        mul_next;
   logic [VW-1:0]        quo_ext;

   tsac_div #(
      .NUM_W (PW),
      .DEN_W (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      // Offset and span, each split into sign and magnitude.
      avg       = div_quo[CW-1:0];
      diff      = {1'b0, avg} - {1'b0, raw_min};
      diff_flip = ~diff + 1'b1;
      span      = {1'b0, raw_max} - {1'b0, raw_min};
      span_flip = ~span + 1'b1;
      diff_mag  = diff[CW] ? diff_flip[CW-1:0] : diff[CW-1:0];

      // One multiplier bit per cycle: add size to the high half, shift right.
      mul_add  = {1'b0, prod_ff[PW-1:CW]} + (prod_ff[0] ? {1'b0, size} : '0);
      mul_next = {mul_add, prod_ff[CW-1:1]};

      quo_ext = {1'b0, div_quo};

      state_in     = state_ff;
      prod_in      = prod_ff;
      mcnt_in      = mcnt_ff;
      neg_in       = neg_ff;
      span_zero_in = span_zero_ff;
      span_mag_in  = span_mag_ff;
      low_in       = low_ff;
      value_in     = value_ff;
      done_in      = 1'b0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;

      case (state_ff)
         AX_IDLE: begin
            if (start) begin
               div_start = 1'b1;
               div_num   = PW'(sum);
               div_den   = CW'(SAMPLES);
               state_in  = AX_AVG;
            end
         end
         AX_AVG: begin
            if (div_done) begin
               low_in       = (avg < CW'(tsac_pkg::REJECT_BELOW));
               neg_in       = diff[CW] ^ span[CW];
               span_zero_in = (span == '0);
               span_mag_in  = span[CW] ? span_flip[CW-1:0] : span[CW-1:0];
               prod_in      = {{CW{1'b0}}, diff_mag};
               mcnt_in      = '0;
               state_in     = AX_MUL;
            end
         end
         AX_MUL: begin
            prod_in = mul_next;
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == MCNT_W'(MUL_STEPS - 1)) begin
               div_start = 1'b1;
               div_num   = mul_next;
               div_den   = span_mag_ff;
               state_in  = AX_DIV;
            end
         end
         AX_DIV: begin
            if (div_done) begin
               if (span_zero_ff) begin
                  value_in = '0;
               end else if (neg_ff) begin
                  value_in = -$signed(quo_ext);
               end else begin
                  value_in = $signed(quo_ext);
               end
               done_in  = 1'b1;
               state_in = AX_IDLE;
            end
         end
         default: begin
            state_in = AX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AX_IDLE;
         done_ff  <= 1'b0;
         mcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         mcnt_ff  <= mcnt_in;
      end
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      span_zero_ff <= span_zero_in;
      span_mag_ff  <= span_mag_in;
      low_ff       <= low_in;
      value_ff     <= value_in;
   end

   assign stat.done  = done_ff;
   assign stat.low   = low_ff;
   assign stat.value = value_ff;

endmodule

// ===== rtl/touch_sample_average_and_calibrate_top.sv =====
// ----------------------------------------------------------------------------
// Touch sample averaging and calibration, top level
// Request words carry a pen-down flag and raw X/Y converter samples. While
// the pen is down, samples are summed; every SAMPLES-th sample closes a batch,
// whose averages are checked against a floor of 32 and mapped linearly onto
// the screen with optional invert and swap, then clamped to the screen area.
// A pen-up word clears the batch and gives a not-touched response at once.
// A word that only adds to a batch gives no response.
//
// A pen-up word shows on rsp_valid in the cycle after it is taken. A word
// that closes a batch runs two passes of the 24-bit serial divider
// (average, then mapping) and 12 steps of the serial multiplier, for X
// and Y side by side in two lanes. No new request word is taken until
// the response for that batch is written.
// Reset clears the batch, empties the response register and loads the default
// calibration. While rsp_stall holds a response, the response stays put and
// req_stall is raised; configuration writes are taken at any time but are
// meant for an idle block.
// ----------------------------------------------------------------------------
module touch_sample_average_and_calibrate_top #(
   parameter int SAMPLES  = tsac_pkg::SAMPLES_DEF,
   parameter int RAW_BITS = tsac_pkg::RAW_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_pen_down,
   input  logic [tsac_pkg::RAW_W-1:0]         req_raw_x,
   input  logic [tsac_pkg::RAW_W-1:0]         req_raw_y,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_touched,
   output logic [tsac_pkg::POS_W-1:0]         rsp_x_pos,
   output logic [tsac_pkg::POS_W-1:0]         rsp_y_pos,
   // Configuration port
   input  logic                               csr_write,
   input  logic [tsac_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tsac_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int CW    = tsac_pkg::CFG_W;
   localparam int RW    = tsac_pkg::RAW_W;
   localparam int PSW   = tsac_pkg::POS_W;
   localparam int OW    = tsac_pkg::ORIENT_W;
   localparam int FW    = tsac_pkg::FIN_W;
   localparam int SUM_W = RW + $clog2(SAMPLES);
   localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam logic [RW-1:0] RAW_MASK =
      (RAW_BITS >= RW) ? {RW{1'b1}} : RW'((1 << RAW_BITS) - 1);

   localparam logic [1:0] CT_IDLE = 2'd0;
   localparam logic [1:0] CT_CALC = 2'd1;
   localparam logic [1:0] CT_POST = 2'd2;

   // Configuration registers.
   logic [CW-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic [CW-1:0] width_ff, height_ff;
   logic [OW-1:0] orient_ff;

   // Batch and control.
   logic [1:0]       state_ff, state_in;
   logic [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Response register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_touched_ff, rsp_touched_in;
   logic [PSW-1:0]   rsp_x_ff, rsp_x_in;
   logic [PSW-1:0]   rsp_y_ff, rsp_y_in;

   logic             accept;
   logic             out_free;
   logic             batch_done;
   logic             axis_start;
   logic [SUM_W-1:0] sum_x_next;
   logic [SUM_W-1:0] sum_y_next;

   tsac_pkg::axis_stat_type stat_x;
   tsac_pkg::axis_stat_type stat_y;

   logic signed [FW-1:0] px_raw, py_raw;
   logic signed [FW-1:0] px_inv, py_inv;
   logic signed [FW-1:0] px_fin, py_fin;

   // Handshake.
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != CT_IDLE) | ~out_free;
   assign accept    = req_valid & ~req_stall;

   // Running sums including the word on the request port.
   assign sum_x_next = sum_x_ff + SUM_W'(req_raw_x & RAW_MASK);
   assign sum_y_next = sum_y_ff + SUM_W'(req_raw_y & RAW_MASK);
   assign batch_done = (cnt_ff == CNT_W'(SAMPLES - 1));
   assign axis_start = accept & req_pen_down & batch_done;

   tsac_axis #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W)
   ) u_axis_x (
      .clock   (clock),
      .reset   (reset),
      .start   (axis_start),
      .sum     (sum_x_next),
      .raw_min (x_min_ff),
      .raw_max (x_max_ff),
      .size    (width_ff),
      .stat    (stat_x)
   );

   tsac_axis #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W)
   ) u_axis_y (
      .clock   (clock),
      .reset   (reset),
      .start   (axis_start),
      .sum     (sum_y_next),
      .raw_min (y_min_ff),
      .raw_max (y_max_ff),
      .size    (height_ff),
      .stat    (stat_y)
   );

   // Invert each axis against its own size, then swap if asked.
   always_comb begin
      px_raw = FW'(stat_x.value);
      py_raw = FW'(stat_y.value);
      px_inv = orient_ff[tsac_pkg::ORIENT_INV_X]
               ? $signed({{(FW-CW){1'b0}}, width_ff}) - px_raw : px_raw;
      py_inv = orient_ff[tsac_pkg::ORIENT_INV_Y]
               ? $signed({{(FW-CW){1'b0}}, height_ff}) - py_raw : py_raw;
      px_fin = orient_ff[tsac_pkg::ORIENT_SWAP] ? py_inv : px_inv;
      py_fin = orient_ff[tsac_pkg::ORIENT_SWAP] ? px_inv : py_inv;
   end

   // Batch, sequencing and response register.
   always_comb begin
      state_in       = state_ff;
      sum_x_in       = sum_x_ff;
      sum_y_in       = sum_y_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_touched_in = rsp_touched_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;

      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         CT_IDLE: begin
            if (accept) begin
               if (!req_pen_down) begin
                  sum_x_in       = '0;
                  sum_y_in       = '0;
                  cnt_in         = '0;
                  rsp_valid_in   = 1'b1;
                  rsp_touched_in = 1'b0;
                  rsp_x_in       = '0;
                  rsp_y_in       = '0;
               end else if (batch_done) begin
                  sum_x_in = '0;
                  sum_y_in = '0;
                  cnt_in   = '0;
                  state_in = CT_CALC;
               end else begin
                  sum_x_in = sum_x_next;
                  sum_y_in = sum_y_next;
                  cnt_in   = cnt_ff + 1'b1;
               end
            end
         end
         CT_CALC: begin
            if (stat_x.done) begin
               state_in = CT_POST;
            end
         end
         CT_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (stat_x.low | stat_y.low) begin
                  rsp_touched_in = 1'b0;
                  rsp_x_in       = '0;
                  rsp_y_in       = '0;
               end else begin
                  rsp_touched_in = 1'b1;
                  rsp_x_in       = tsac_pkg::clamp_pos(px_fin, width_ff);
                  rsp_y_in       = tsac_pkg::clamp_pos(py_fin, height_ff);
               end
               state_in = CT_IDLE;
            end
         end
         default: begin
            state_in = CT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CT_IDLE;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_touched_ff <= rsp_touched_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
   end

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff  <= tsac_pkg::RST_RAW_MIN;
         x_max_ff  <= tsac_pkg::RST_RAW_MAX;
         y_min_ff  <= tsac_pkg::RST_RAW_MIN;
         y_max_ff  <= tsac_pkg::RST_RAW_MAX;
         width_ff  <= tsac_pkg::RST_SIZE;
         height_ff <= tsac_pkg::RST_SIZE;
         orient_ff <= tsac_pkg::RST_ORIENT;
      end else if (csr_write) begin
         case (csr_index)
            tsac_pkg::REG_X_MIN:  x_min_ff  <= csr_wdata;
            tsac_pkg::REG_X_MAX:  x_max_ff  <= csr_wdata;
            tsac_pkg::REG_Y_MIN:  y_min_ff  <= csr_wdata;
            tsac_pkg::REG_Y_MAX:  y_max_ff  <= csr_wdata;
            tsac_pkg::REG_WIDTH:  width_ff  <= csr_wdata;
            tsac_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            tsac_pkg::REG_ORIENT: orient_ff <= csr_wdata[OW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_touched = rsp_touched_ff;
   assign rsp_x_pos   = rsp_x_ff;
   assign rsp_y_pos   = rsp_y_ff;

endmodule

// ===== rtl/tsac_checker.sv =====
// ----------------------------------------------------------------------------
// Touch sample averaging and calibration: port checker
// Watches the top-level ports and flags responses that break the block's
// rules, attached to the top level by a bind.
// ----------------------------------------------------------------------------
module tsac_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_pen_down,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_touched,
   input logic [tsac_pkg::POS_W-1:0]     rsp_x_pos,
   input logic [tsac_pkg::POS_W-1:0]     rsp_y_pos
);

   // A stalled response word holds its place and contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_touched)
         && $stable(rsp_x_pos) && $stable(rsp_y_pos))
      else $error("stalled response word changed");

   // A not-touched response reports the origin.
   a_untouched_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_touched |-> rsp_x_pos == '0 && rsp_y_pos == '0)
      else $error("not-touched response with nonzero position");

   // A pen-up word is answered on the next cycle with a not-touched word.
   a_pen_up_reply: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_pen_down |=> rsp_valid && !rsp_touched)
      else $error("pen-up word not answered in one cycle");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind touch_sample_average_and_calibrate_top tsac_checker u_tsac_checker (.*);
